@@ rtl/mstt_pkg.sv @@
`timescale 1ns / 1ps

package mstt_pkg;

  localparam int TIME_W   = 31;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 4;
  localparam int COUNT_W  = 4;

  localparam int US_PER_SECOND  = 1000000;
  localparam int RESET_PERIOD_S = 8;
  localparam logic [TIME_W-1:0] RESET_PERIOD_US = TIME_W'(US_PER_SECOND * RESET_PERIOD_S);

  // slot phase codes
  localparam logic [1:0] PH_FREE    = 2'd0;
  localparam logic [1:0] PH_RUN     = 2'd1;
  localparam logic [1:0] PH_EXPIRED = 2'd2;

  // item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_RUN    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_BADSLOT = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // result of the shared subtract-compare unit
  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              lt;
    logic              zero;
  } mstt_sub_t;

endpackage

@@ rtl/mstt_subcmp.sv @@
`timescale 1ns / 1ps

module mstt_subcmp
  import mstt_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output mstt_sub_t         res
);

  logic [TIME_W:0] full;

  // borrow out of the extended difference means a < b
  assign full     = {1'b0, a} - {1'b0, b};
  assign res.diff = full[TIME_W-1:0];
  assign res.lt   = full[TIME_W];
  assign res.zero = (full[TIME_W-1:0] == '0);

endmodule

@@ rtl/multi_slot_timer_table.sv @@
`timescale 1ns / 1ps
// sequence: an item goes from idle through the slot walk to done, where its result is registered;
//   remove visits only its slot; a bad slot or a run next with the scan pointer past the table skips the walk
// throughput: one item at a time; the slot walk runs one slot per cycle
//   through one subtract-compare unit
// reset: synchronous active-low rst_n frees every slot, clears the expired count and scan
//   pointer and loads 8000000 us into max period and next period; no clearing pass

module multi_slot_timer_table
  import mstt_pkg::*;
#(
  parameter int SLOTS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  // configuration: max_period_us
  input  logic          cfg_wr_en,
  input  logic [30:0]   cfg_wr_data,
  // input channel
  input  logic          in_tvalid,
  output logic          in_tready,
  // duration_us[30:0], user_value[62:31], slot_id[66:63], elapsed_us[97:67], zero pad
  input  logic [103:0]  in_tdata,
  // mode[1:0]
  input  logic [1:0]    in_tuser,
  // result channel
  output logic          out_tvalid,
  input  logic          out_tready,
  // slot_index[3:0], fired_value[35:4], expired_count[39:36], next_period_us[70:40], pad
  output logic [71:0]   out_tdata,
  // status[1:0]
  output logic [1:0]    out_tuser
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] NUM_SLOTS = IDX_W'(SLOTS);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // slot table: remaining time and payload have no reset, phase is cleared by reset
  logic [TIME_W-1:0]  slot_rem_r   [SLOTS];
  logic [VALUE_W-1:0] slot_pay_r   [SLOTS];
  logic [1:0]         slot_phase_r [SLOTS];

  logic [1:0]          state_r,     state_nxt;
  logic [IDX_W-1:0]    cnt_r,       cnt_nxt;
  logic [IDX_W-1:0]    scan_ptr_r,  scan_ptr_nxt;
  logic [COUNT_W-1:0]  exp_total_r, exp_total_nxt;
  logic [TIME_W-1:0]   next_per_r,  next_per_nxt;
  logic [TIME_W-1:0]   max_per_r;
  logic [TIME_W-1:0]   shortest_r,  shortest_nxt;

  // latched item
  logic [1:0]          mode_r;
  logic [TIME_W-1:0]   dur_r;
  logic [VALUE_W-1:0]  uval_r;
  logic [TIME_W-1:0]   elapsed_r;

  // pending result
  logic [1:0]          res_st_r,   res_st_nxt;
  logic [IDX_W-1:0]    res_idx_r,  res_idx_nxt;
  logic [VALUE_W-1:0]  res_val_r,  res_val_nxt;

  logic                out_valid_r;
  logic [71:0]         out_data_r;
  logic [1:0]          out_user_r;

  // table write strobes, always at the slot under the counter
  logic                ph_we;
  logic [1:0]          ph_wd;
  logic                rem_we;
  logic [TIME_W-1:0]   rem_wd;
  logic                pay_we;

  logic                in_xfer;
  logic                out_load;
  logic [IW-1:0]       sel;
  logic [1:0]          cur_phase;
  logic [TIME_W-1:0]   in_dur;
  logic [IDX_W-1:0]    in_sid;
  logic [TIME_W-1:0]   alu_a, alu_b;
  mstt_sub_t           alu;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign sel       = cnt_r[IW-1:0];
  assign cur_phase = slot_phase_r[sel];
  assign in_dur    = in_tdata[30:0];
  assign in_sid    = in_tdata[66:63];

  // shared unit: tick subtracts the elapsed time, set compares against the period
  always_comb begin
    if (mode_r == MODE_TICK) begin
      alu_a = slot_rem_r[sel];
      alu_b = elapsed_r;
    end else begin
      alu_a = dur_r;
      alu_b = next_per_r;
    end
  end

  mstt_subcmp u_sub (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scan_ptr_nxt  = scan_ptr_r;
    exp_total_nxt = exp_total_r;
    next_per_nxt  = next_per_r;
    shortest_nxt  = shortest_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    res_val_nxt   = res_val_r;
    ph_we         = 1'b0;
    ph_wd         = PH_FREE;
    rem_we        = 1'b0;
    rem_wd        = alu.diff;
    pay_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_st_nxt   = ST_OK;
          res_idx_nxt  = '0;
          res_val_nxt  = '0;
          shortest_nxt = max_per_r;
          state_nxt    = S_SCAN;
          case (in_tuser)
            MODE_REMOVE: begin
              cnt_nxt = in_sid;
              // slot id past the table: answer at once
              if (in_sid >= NUM_SLOTS) begin
                res_st_nxt = ST_BADSLOT;
                state_nxt  = S_DONE;
              end
            end
            MODE_RUN: begin
              cnt_nxt = scan_ptr_r;
              if (scan_ptr_r >= NUM_SLOTS) begin
                scan_ptr_nxt = NUM_SLOTS;
                res_st_nxt   = ST_NONE;
                state_nxt    = S_DONE;
              end
            end
            default: cnt_nxt = '0;
          endcase
        end
      end

      S_SCAN: begin
        case (mode_r)
          MODE_TICK: begin
            if (cur_phase == PH_RUN) begin
              rem_we = 1'b1;
              if (alu.lt || alu.zero) begin
                // saturate at zero and expire
                rem_wd = '0;
                ph_we  = 1'b1;
                ph_wd  = PH_EXPIRED;
                if (exp_total_r != COUNT_MAX) exp_total_nxt = exp_total_r + 1'b1;
              end else if (alu.diff < shortest_r) begin
                shortest_nxt = alu.diff;
              end
            end
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == LAST_SLOT) begin
              next_per_nxt = shortest_nxt;
              scan_ptr_nxt = '0;
              state_nxt    = S_DONE;
            end
          end
          MODE_SET: begin
            if (cur_phase == PH_FREE) begin
              rem_we      = 1'b1;
              rem_wd      = dur_r;
              pay_we      = 1'b1;
              ph_we       = 1'b1;
              ph_wd       = PH_RUN;
              res_idx_nxt = cnt_r;
              if (alu.lt) next_per_nxt = dur_r;
              state_nxt   = S_DONE;
            end else if (cnt_r == LAST_SLOT) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          MODE_REMOVE: begin
            // removing an expired slot takes it off the count
            if (cur_phase == PH_EXPIRED && exp_total_r != '0)
              exp_total_nxt = exp_total_r - 1'b1;
            ph_we       = 1'b1;
            ph_wd       = PH_FREE;
            res_idx_nxt = cnt_r;
            state_nxt   = S_DONE;
          end
          default: begin
            if (cur_phase == PH_EXPIRED) begin
              ph_we        = 1'b1;
              ph_wd        = PH_FREE;
              if (exp_total_r != '0) exp_total_nxt = exp_total_r - 1'b1;
              scan_ptr_nxt = cnt_r;
              res_idx_nxt  = cnt_r;
              res_val_nxt  = slot_pay_r[sel];
              state_nxt    = S_DONE;
            end else if (cnt_r == LAST_SLOT) begin
              scan_ptr_nxt = NUM_SLOTS;
              res_st_nxt   = ST_NONE;
              state_nxt    = S_DONE;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        endcase
      end

      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_ptr_r  <= '0;
      exp_total_r <= '0;
      next_per_r  <= RESET_PERIOD_US;
      max_per_r   <= RESET_PERIOD_US;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      exp_total_r <= exp_total_nxt;
      next_per_r  <= next_per_nxt;
      // zero max period is held at one
      if (cfg_wr_en) max_per_r <= (cfg_wr_data == '0) ? TIME_W'(1) : cfg_wr_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // phase array, cleared to free by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_phase_r[i] <= PH_FREE;
    end else if (ph_we) begin
      slot_phase_r[sel] <= ph_wd;
    end
  end

  // remaining time and payload, undefined until written
  always_ff @(posedge clk) begin
    if (rem_we) slot_rem_r[sel] <= rem_wd;
    if (pay_we) slot_pay_r[sel] <= uval_r;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    shortest_r <= shortest_nxt;
    res_st_r   <= res_st_nxt;
    res_idx_r  <= res_idx_nxt;
    res_val_r  <= res_val_nxt;
    if (in_xfer) begin
      mode_r    <= in_tuser;
      // zero duration clamps to one
      dur_r     <= (in_dur == '0) ? TIME_W'(1) : in_dur;
      uval_r    <= in_tdata[62:31];
      elapsed_r <= in_tdata[97:67];
    end
    if (out_load) begin
      out_user_r <= res_st_r;
      out_data_r <= {1'b0, next_per_r, exp_total_r, res_val_r, res_idx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ rtl/mstt_checker.sv @@
`timescale 1ns / 1ps

module mstt_checker
  import mstt_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // only a successful run next carries a value; failures carry slot zero
  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[35:4] == '0 && out_tdata[3:0] == '0)
    else $error("failed result carries a slot or value");

  // the reported period is never zero
  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[70:40] != '0)
    else $error("zero next period");

endmodule

bind multi_slot_timer_table mstt_checker u_mstt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/multi_slot_timer_table_tb.sv @@
`timescale 1ns / 1ps

module multi_slot_timer_table_tb;
  import mstt_pkg::*;

  localparam int NUM_SLOTS   = 10;
  localparam int MAX_WAIT    = 6;
  localparam int RAND_ITEMS  = 800;
  localparam int NUM_PHASES  = 6;
  localparam int SETTLE      = 2 * NUM_SLOTS + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // one command to the timer table
  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] duration_us;
    logic [31:0] user_value;
    logic [3:0]  slot_id;
    logic [30:0] elapsed_us;
  } timer_cmd_t;

  // one answer from the timer table
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] fired_value;
    logic [3:0]  expired_count;
    logic [30:0] next_period_us;
  } timer_res_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_wr_en;
  logic [30:0]   cfg_wr_data;
  logic          in_tvalid;
  logic          in_tready;
  logic [103:0]  in_tdata;
  logic [1:0]    in_tuser;
  logic          out_tvalid;
  logic          out_tready;
  logic [71:0]   out_tdata;
  logic [1:0]    out_tuser;

  // predicted copy of the table
  logic [1:0]    tbl_phase [NUM_SLOTS];
  logic [30:0]   tbl_left [NUM_SLOTS];
  logic [31:0]   tbl_value [NUM_SLOTS];
  logic [3:0]    tbl_expired;
  int            tbl_scan;
  logic [30:0]   tbl_period;
  logic [30:0]   tbl_max_period;

  timer_cmd_t    cmd_backlog[$];
  timer_res_t    awaited_results[$];
  timer_cmd_t    cur_cmd;

  int            n_queued;
  int            n_accepted;
  int            n_checked;
  int            n_fired;
  int            n_full;
  int            n_settings;
  int            failures;
  int            in_gap;
  int            out_stall;
  int            cycles;
  logic          steady;

  multi_slot_timer_table #(
    .SLOTS (NUM_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #4 clk = ~clk;

  // applies one command to the predicted table and returns the answer it should give
  function automatic timer_res_t table_result(timer_cmd_t c);
    timer_res_t  r;
    logic [30:0] shortest;
    logic [30:0] dur;
    int          i;
    int          free_slot;
    int          p;
    r = '0;
    case (c.mode)
      MODE_TICK: begin
        // saturating subtract on every running slot, rescan for the shortest one
        shortest = tbl_max_period;
        tbl_scan = 0;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (tbl_phase[i] == PH_RUN) begin
            if (tbl_left[i] <= c.elapsed_us) begin
              tbl_left[i]  = '0;
              tbl_phase[i] = PH_EXPIRED;
              if (tbl_expired != COUNT_MAX) tbl_expired++;
            end else begin
              tbl_left[i] = tbl_left[i] - c.elapsed_us;
              if (tbl_left[i] < shortest) shortest = tbl_left[i];
            end
          end
        end
        tbl_period = shortest;
        r.status   = ST_OK;
      end
      MODE_SET: begin
        // lowest free slot wins
        free_slot = -1;
        for (i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (tbl_phase[i] == PH_FREE) free_slot = i;
        end
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          dur = (c.duration_us == '0) ? 31'd1 : c.duration_us;
          tbl_left[free_slot]  = dur;
          tbl_value[free_slot] = c.user_value;
          tbl_phase[free_slot] = PH_RUN;
          if (dur < tbl_period) tbl_period = dur;
          r.status     = ST_OK;
          r.slot_index = 4'(free_slot);
        end
      end
      MODE_REMOVE: begin
        if (c.slot_id >= NUM_SLOTS) begin
          r.status = ST_BADSLOT;
        end else begin
          if (tbl_phase[c.slot_id] == PH_EXPIRED && tbl_expired != '0) tbl_expired--;
          tbl_phase[c.slot_id] = PH_FREE;
          r.status     = ST_OK;
          r.slot_index = c.slot_id;
        end
      end
      default: begin
        // run next: search from the scan pointer, which only a tick rewinds
        p = tbl_scan;
        while (p < NUM_SLOTS && tbl_phase[p] != PH_EXPIRED) p++;
        if (p < NUM_SLOTS) begin
          tbl_phase[p] = PH_FREE;
          if (tbl_expired != '0) tbl_expired--;
          tbl_scan      = p;
          r.status      = ST_OK;
          r.slot_index  = 4'(p);
          r.fired_value = tbl_value[p];
        end else begin
          tbl_scan = NUM_SLOTS;
          r.status = ST_NONE;
        end
      end
    endcase
    r.expired_count  = tbl_expired;
    r.next_period_us = tbl_period;
    return r;
  endfunction

  // mostly small times so that timers expire often; the unused fields carry noise
  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int         pick;
    c.duration_us = 31'($urandom);
    c.user_value  = $urandom;
    c.slot_id     = 4'($urandom);
    c.elapsed_us  = 31'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 32) c.mode = MODE_SET;
    else if (pick < 56) c.mode = MODE_TICK;
    else if (pick < 80) c.mode = MODE_RUN;
    else c.mode = MODE_REMOVE;
    pick = $urandom_range(0, 99);
    if (pick < 8) c.duration_us = '0;
    else if (pick < 85) c.duration_us = 31'($urandom_range(1, 3000));
    pick = $urandom_range(0, 99);
    if (pick < 10) c.elapsed_us = '0;
    else if (pick < 85) c.elapsed_us = 31'($urandom_range(0, 2000));
    if ($urandom_range(0, 99) < 85) c.slot_id = 4'($urandom_range(0, NUM_SLOTS - 1));
    return c;
  endfunction

  task automatic queue_cmd(input logic [1:0] mode, input logic [30:0] dur,
                           input logic [31:0] val, input logic [3:0] sid,
                           input logic [30:0] elapsed);
    timer_cmd_t c;
    c.mode        = mode;
    c.duration_us = dur;
    c.user_value  = val;
    c.slot_id     = sid;
    c.elapsed_us  = elapsed;
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  // every queued command accepted and answered, then let the block settle
  task automatic wait_idle();
    while (n_accepted != n_queued || awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max_period(input logic [30:0] period);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= period;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    // a zero period is held at one
    tbl_max_period = (period == '0) ? 31'd1 : period;
    n_settings++;
  endtask

  // input driver: one gap draw per command, valid held while the block stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = $urandom_range(0, MAX_WAIT);
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(table_result(cur_cmd));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_tdata  <= {6'd0, cur_cmd.elapsed_us, cur_cmd.slot_id, cur_cmd.user_value,
                        cur_cmd.duration_us};
          in_tuser  <= cur_cmd.mode;
          in_tvalid <= 1'b1;
          in_gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each transfer against the oldest predicted answer
  always @(posedge clk) begin : result_monitor
    timer_res_t got;
    timer_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = $urandom_range(0, MAX_WAIT);
    end else begin
      if (out_tvalid && out_tready) begin
        got.status         = out_tuser;
        got.slot_index     = out_tdata[3:0];
        got.fired_value    = out_tdata[35:4];
        got.expired_count  = out_tdata[39:36];
        got.next_period_us = out_tdata[70:40];
        n_checked++;
        if (awaited_results.size() == 0) begin
          if (failures < MAX_REPORTS)
            $display("unexpected result at cycle %0d: status %0d slot %0d", cycles,
                     got.status, got.slot_index);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (want.status == ST_OK && want.fired_value != '0) n_fired++;
          if (want.status == ST_FULL) n_full++;
          if (got !== want) begin
            if (failures < MAX_REPORTS) begin
              $write("result %0d differs (expected/actual): status %0d/%0d slot %0d/%0d ",
                     n_checked, want.status, got.status, want.slot_index, got.slot_index);
              $display("fired %0d/%0d count %0d/%0d period %0d/%0d",
                       $signed(want.fired_value), $signed(got.fired_value),
                       want.expired_count, got.expired_count,
                       want.next_period_us, got.next_period_us);
            end
            failures++;
          end
        end
        out_stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // cycle limit, plus stretches where neither side idles
  always @(posedge clk) begin
    cycles++;
    if (cycles % 64 == 0) steady <= ($urandom_range(0, 3) == 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               awaited_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          k;
    logic [30:0] period;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    steady      = 1'b0;
    n_queued    = 0;
    n_accepted  = 0;
    n_checked   = 0;
    n_fired     = 0;
    n_full      = 0;
    n_settings  = 0;
    failures    = 0;
    cycles      = 0;
    for (k = 0; k < NUM_SLOTS; k++) begin
      tbl_phase[k] = PH_FREE;
      tbl_left[k]  = '0;
      tbl_value[k] = '0;
    end
    tbl_expired    = '0;
    tbl_scan       = 0;
    tbl_period     = RESET_PERIOD_US;
    tbl_max_period = RESET_PERIOD_US;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset period
    queue_cmd(MODE_TICK, '0, '0, '0, '0);               // empty table tick
    queue_cmd(MODE_RUN, '0, '0, '0, '0);                // nothing expired
    queue_cmd(MODE_REMOVE, '0, '0, 4'd15, '0);          // out of range
    queue_cmd(MODE_REMOVE, '0, '0, 4'(NUM_SLOTS), '0);  // first bad index
    queue_cmd(MODE_REMOVE, '0, '0, 4'd3, '0);           // free slot
    queue_cmd(MODE_SET, '0, 32'h8000_0000, '0, '0);     // zero duration clamps to one
    queue_cmd(MODE_SET, 31'h7fff_ffff, 32'h7fff_ffff, '0, '0);
    queue_cmd(MODE_SET, 31'd1000, 32'hffff_ffff, '0, '0);
    queue_cmd(MODE_TICK, '0, '0, '0, 31'd1);            // elapsed equals remaining
    queue_cmd(MODE_TICK, '0, '0, '0, 31'h7fff_ffff);    // everything saturates
    queue_cmd(MODE_RUN, '0, '0, '0, '0);
    queue_cmd(MODE_REMOVE, '0, '0, 4'd1, '0);           // expired slot, count drops
    queue_cmd(MODE_RUN, '0, '0, '0, '0);
    queue_cmd(MODE_RUN, '0, '0, '0, '0);                // scan runs off the end
    for (k = 0; k < NUM_SLOTS; k++)
      queue_cmd(MODE_SET, 31'(k * 100 + 1), $urandom, '0, '0);
    queue_cmd(MODE_SET, 31'd5, 32'h1234_5678, '0, '0);  // table full
    wait_idle();

    // random part over several max period settings, extremes first
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: period = 31'd1;
        1: period = '0;
        2: period = 31'h7fff_ffff;
        3: period = 31'd1500;
        4: period = 31'($urandom_range(1, 4000));
        default: period = RESET_PERIOD_US;
      endcase
      write_max_period(period);
      for (k = 0; k < RAND_ITEMS / NUM_PHASES; k++) begin
        cmd_backlog.push_back(random_cmd());
        n_queued++;
      end
      wait_idle();
    end

    failures += awaited_results.size();
    $display("%0d commands over %0d max period settings, %0d answers checked", n_accepted,
             n_settings + 1, n_checked);
    $display("%0d timers fired with a nonzero value, %0d sets refused on a full table",
             n_fired, n_full);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mstt_pkg.sv
rtl/mstt_subcmp.sv
rtl/multi_slot_timer_table.sv
rtl/mstt_checker.sv
verif/multi_slot_timer_table_tb.sv
